[rtl/fpba_pkg.sv]
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and codes for the fit-policy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  localparam int NUM_BLOCKS_DEF = 8;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int AMOUNT_W = 16;
  localparam int INDEX_W  = 3;
  localparam int POLICY_W = 2;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // placement policy codes; the unused code behaves as first fit
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  typedef struct packed {
    logic                command;
    logic [INDEX_W-1:0]  load_index;
    logic [AMOUNT_W-1:0] amount;
  } request_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] granted_index;
  } result_t;

endpackage

`default_nettype wire

[rtl/fit_policy_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Block allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken on a clock edge with start high and
//   busy low. A load item writes one slot's capacity and frees the slot;
//   it completes at the accepting edge, gives no result and leaves busy low.
//   An allocate item raises busy while the capacity store is walked one
//   entry per cycle through its single read port, one comparator keeping
//   the running choice. busy stays high until the last entry is compared;
//   done then pulses for one cycle with result valid, and the chosen slot is
//   marked in use at the same edge. No new item is taken while busy; the
//   next item can be taken in the done cycle. Loads are taken one per cycle
//   while busy is low.
//   Configuration: cfg_valid/cfg_ready write the fit policy; cfg_ready is
//   always high and writes are expected only while idle.
//   Reset: policy returns to first fit and every slot reads as in use, so
//   nothing can be granted until loaded. Capacity contents are not cleared.
//   The result receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator_unit #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire fpba_pkg::request_t                request,
  output logic                                   done,
  output fpba_pkg::result_t                      result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fpba_pkg::POLICY_W-1:0]     cfg_data
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CMP_W = (SIZE_BITS > fpba_pkg::AMOUNT_W) ? SIZE_BITS : fpba_pkg::AMOUNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;

  logic [fpba_pkg::POLICY_W-1:0] fit_policy;
  logic [NUM_BLOCKS-1:0]         in_use;
  logic [fpba_pkg::AMOUNT_W-1:0] req_amount;

  logic             issuing;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;

  logic             have;
  logic [IDX_W-1:0] best_idx;
  logic [SIZE_BITS-1:0] best_cap;

  logic             have_next;
  logic [IDX_W-1:0] best_idx_next;
  logic [SIZE_BITS-1:0] best_cap_next;

  logic                 accept;
  logic                 is_load;
  logic                 slot_ok;
  logic [IDX_W+2:0]     load_wide;
  logic [IDX_W+2:0]     grant_wide;
  logic [SIZE_BITS-1:0] rdata;
  logic                 candidate;
  logic                 take;
  logic                 scan_end;

  assign accept    = start && !busy;
  assign is_load   = accept && (request.command == fpba_pkg::CMD_LOAD);
  assign slot_ok   = 32'(request.load_index) < 32'(NUM_BLOCKS);
  assign load_wide = {IDX_W'(0), request.load_index};
  assign busy      = (state == ST_SCAN);
  assign cfg_ready = 1'b1;

  fpba_cap_mem #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (SIZE_BITS),
    .AW    (IDX_W)
  ) u_cap_mem (
    .clk   (clk),
    .we    (is_load && slot_ok),
    .waddr (load_wide[IDX_W-1:0]),
    .wdata (SIZE_BITS'(request.amount)),
    .re    (busy && issuing),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // running choice; strict compares keep the lowest index on ties
  always_comb begin
    candidate = !in_use[rd_idx] && (CMP_W'(rdata) >= CMP_W'(req_amount));
    take = 1'b0;
    if (candidate) begin
      if (!have) begin
        take = 1'b1;
      end else if (fit_policy == fpba_pkg::POL_BEST) begin
        take = rdata < best_cap;
      end else if (fit_policy == fpba_pkg::POL_WORST) begin
        take = rdata > best_cap;
      end
    end
    have_next     = have || take;
    best_idx_next = take ? rd_idx : best_idx;
    best_cap_next = take ? rdata : best_cap;
    scan_end      = rd_valid && (rd_idx == LAST_IDX);
    grant_wide    = {3'b000, best_idx_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fit_policy <= fpba_pkg::POL_FIRST;
      in_use     <= '1;
      issuing    <= 1'b0;
      rd_valid   <= 1'b0;
      have       <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        fit_policy <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (is_load && slot_ok) begin
            in_use[load_wide[IDX_W-1:0]] <= 1'b0;
          end
          if (accept && (request.command == fpba_pkg::CMD_ALLOC)) begin
            state   <= ST_SCAN;
            issuing <= 1'b1;
            have    <= 1'b0;
          end
        end
        ST_SCAN: begin
          rd_valid <= issuing;
          if (issuing && (rd_addr == LAST_IDX)) begin
            issuing <= 1'b0;
          end
          if (rd_valid) begin
            have <= have_next;
          end
          if (scan_end) begin
            state <= ST_IDLE;
            done  <= 1'b1;
            if (have_next) begin
              in_use[best_idx_next] <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && (request.command == fpba_pkg::CMD_ALLOC)) begin
      req_amount <= request.amount;
      rd_addr    <= '0;
    end else if (busy && issuing && (rd_addr != LAST_IDX)) begin
      rd_addr <= rd_addr + 1'b1;
    end
    rd_idx <= rd_addr;
    if (rd_valid) begin
      best_idx <= best_idx_next;
      best_cap <= best_cap_next;
    end
    if (scan_end) begin
      result.found         <= have_next;
      result.granted_index <= have_next ? grant_wide[2:0] : '0;
    end
  end

endmodule

`default_nettype wire

[rtl/fpba_cap_mem.sv]
// ----------------------------------------------------------------------------
// fpba_cap_mem
// Block capacity store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_cap_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16,
  parameter int AW    = 3
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/fpba_checker.sv]
// ----------------------------------------------------------------------------
// fpba_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire fpba_pkg::request_t request,
  input wire logic               done,
  input wire fpba_pkg::result_t  result
);

  // an allocate item holds the block busy from the next cycle
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (request.command == fpba_pkg::CMD_ALLOC) |=> busy)
    else $error("allocate item did not raise busy");

  // a load item completes at once
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (request.command == fpba_pkg::CMD_LOAD) |=> !busy && !done)
    else $error("load item raised busy or gave a result");

  // a result only ends a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside the end of a search");

  // a miss reports index zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.granted_index == '0)
    else $error("miss with non-zero index");

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fit-policy block allocator. A queue of load
// and allocate items, with policy writes between phases, feeds a clocked
// driver. A shadow table of capacities and in-use marks predicts each grant,
// and the monitor compares every done strobe with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int NBLK = fpba_pkg::NUM_BLOCKS_DEF;
  localparam int DRAIN_CYCLES = NBLK + 4;
  localparam int PHASE_ITEMS = 48;
  localparam logic [fpba_pkg::POLICY_W-1:0] POL_SPARE = 2'd3;

  typedef struct {
    bit                            is_policy;
    logic [fpba_pkg::POLICY_W-1:0] policy;
    fpba_pkg::request_t            req;
    int unsigned                   gap_pct;
  } drive_op_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  fpba_pkg::request_t            req_bus = '0;
  logic                          done;
  fpba_pkg::result_t             result;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fpba_pkg::POLICY_W-1:0] cfg_data = '0;

  drive_op_t                     pending_ops[$];
  fpba_pkg::result_t             expected_grants[$];
  logic [fpba_pkg::AMOUNT_W-1:0] shadow_capacity[NBLK];
  bit                            shadow_in_use[NBLK];
  logic [fpba_pkg::POLICY_W-1:0] shadow_policy = fpba_pkg::POL_FIRST;
  int unsigned                   sender_gap_pct = 0;
  int unsigned                   quiet_cycles = 0;
  int unsigned                   error_count = 0;

  fit_policy_block_allocator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (req_bus),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    foreach (shadow_in_use[i]) shadow_in_use[i] = 1'b1;
  end

  // Shadow of the allocator: loads update the table, allocates search it
  // and push the grant they should produce.
  function automatic void predict_grant(fpba_pkg::request_t req);
    fpba_pkg::result_t            grant;
    logic [fpba_pkg::INDEX_W-1:0] pick;
    bit                           have;
    if (req.command == fpba_pkg::CMD_LOAD) begin
      shadow_capacity[req.load_index] = req.amount;
      shadow_in_use[req.load_index] = 1'b0;
      return;
    end
    have = 1'b0;
    pick = '0;
    for (int i = 0; i < NBLK; i++) begin
      if (!shadow_in_use[i] && shadow_capacity[i] >= req.amount) begin
        if (!have) begin
          have = 1'b1;
          pick = i[fpba_pkg::INDEX_W-1:0];
          if (shadow_policy != fpba_pkg::POL_BEST &&
              shadow_policy != fpba_pkg::POL_WORST) break;
        end else if (shadow_policy == fpba_pkg::POL_BEST &&
                     shadow_capacity[i] < shadow_capacity[pick]) begin
          pick = i[fpba_pkg::INDEX_W-1:0];
        end else if (shadow_policy == fpba_pkg::POL_WORST &&
                     shadow_capacity[i] > shadow_capacity[pick]) begin
          pick = i[fpba_pkg::INDEX_W-1:0];
        end
      end
    end
    if (have) shadow_in_use[pick] = 1'b1;
    grant.found = have;
    grant.granted_index = have ? pick : '0;
    expected_grants.push_back(grant);
  endfunction

  function automatic void queue_item(logic cmd, int unsigned slot, int unsigned amt);
    drive_op_t op;
    op.is_policy = 1'b0;
    op.policy = '0;
    op.req.command = cmd;
    op.req.load_index = slot[fpba_pkg::INDEX_W-1:0];
    op.req.amount = amt[fpba_pkg::AMOUNT_W-1:0];
    op.gap_pct = sender_gap_pct;
    pending_ops.push_back(op);
  endfunction

  function automatic void queue_policy(logic [fpba_pkg::POLICY_W-1:0] pol);
    drive_op_t op;
    op.is_policy = 1'b1;
    op.policy = pol;
    op.req = '0;
    op.gap_pct = 0;
    pending_ops.push_back(op);
  endfunction

  // small values dominate so that equal capacities and exact fits are common
  function automatic int unsigned random_amount();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 16'hFFFF;
      2, 3, 4, 5: return $urandom_range(0, 15);
      6, 7: return $urandom_range(0, 255);
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    logic next_start;
    logic next_cfg_valid;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      next_start = start;
      next_cfg_valid = cfg_valid;
      if (start && !busy) begin
        predict_grant(req_bus);
        void'(pending_ops.pop_front());
        next_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        shadow_policy = cfg_data;
        void'(pending_ops.pop_front());
        next_cfg_valid = 1'b0;
      end
      if (busy || start || expected_grants.size() != 0) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;

      if (!next_start && !next_cfg_valid && pending_ops.size() != 0) begin
        if (pending_ops[0].is_policy) begin
          // policy changes only once the allocator has settled
          if (!start && !busy && expected_grants.size() == 0 &&
              quiet_cycles >= DRAIN_CYCLES) begin
            cfg_data <= pending_ops[0].policy;
            next_cfg_valid = 1'b1;
          end
        end else if ($urandom_range(0, 99) >= pending_ops[0].gap_pct) begin
          req_bus <= pending_ops[0].req;
          next_start = 1'b1;
        end
      end
      start <= next_start;
      cfg_valid <= next_cfg_valid;
    end
  end

  // monitor
  always @(posedge clk) begin
    fpba_pkg::result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result found=%b index=%0d", $time,
                 result.found, result.granted_index);
        error_count++;
      end else begin
        want = expected_grants.pop_front();
        if (result.found !== want.found) begin
          $display("%0t: found mismatch expected %b actual %b", $time,
                   want.found, result.found);
          error_count++;
        end
        if (result.granted_index !== want.granted_index) begin
          $display("%0t: granted_index mismatch expected %0d actual %0d", $time,
                   want.granted_index, result.granted_index);
          error_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [fpba_pkg::POLICY_W-1:0] phase_policy[4];
    int unsigned                   phase_gap[4];
    int unsigned                   count;
    int unsigned                   n;
    phase_policy = '{fpba_pkg::POL_FIRST, fpba_pkg::POL_BEST, fpba_pkg::POL_WORST,
                     POL_SPARE};
    phase_gap = '{0, 83, 0, 8};

    // directed part, first fit from reset
    sender_gap_pct = 0;
    queue_item(fpba_pkg::CMD_ALLOC, 0, 0);            // nothing loaded yet
    queue_item(fpba_pkg::CMD_LOAD, 7, 16'hFFFF);
    queue_item(fpba_pkg::CMD_LOAD, 0, 0);
    queue_item(fpba_pkg::CMD_LOAD, 3, 100);
    queue_item(fpba_pkg::CMD_LOAD, 5, 100);
    queue_item(fpba_pkg::CMD_ALLOC, 0, 0);            // zero request fits slot 0
    queue_item(fpba_pkg::CMD_ALLOC, 0, 16'hFFFF);
    queue_item(fpba_pkg::CMD_ALLOC, 0, 101);          // no fit
    queue_item(fpba_pkg::CMD_ALLOC, 0, 100);
    queue_item(fpba_pkg::CMD_LOAD, 3, 200);           // reload of a slot in use
    queue_item(fpba_pkg::CMD_ALLOC, 7, 150);          // load_index ignored on allocate
    queue_policy(fpba_pkg::POL_BEST);
    queue_item(fpba_pkg::CMD_LOAD, 1, 50);
    queue_item(fpba_pkg::CMD_LOAD, 2, 60);
    queue_item(fpba_pkg::CMD_LOAD, 4, 50);
    queue_item(fpba_pkg::CMD_ALLOC, 6, 40);           // tie between 1 and 4
    queue_item(fpba_pkg::CMD_ALLOC, 0, 55);
    queue_policy(fpba_pkg::POL_WORST);
    queue_item(fpba_pkg::CMD_LOAD, 6, 16'hFFFF);
    queue_item(fpba_pkg::CMD_LOAD, 0, 16'hFFFF);
    queue_item(fpba_pkg::CMD_ALLOC, 0, 1);            // tie between 0 and 6
    queue_item(fpba_pkg::CMD_ALLOC, 0, 1);
    queue_item(fpba_pkg::CMD_ALLOC, 0, 0);
    queue_policy(POL_SPARE);                          // unused code acts as first fit
    queue_item(fpba_pkg::CMD_ALLOC, 0, 0);
    queue_item(fpba_pkg::CMD_ALLOC, 0, 0);

    // random phases: every policy under every idling pattern
    for (int ph = 0; ph < 16; ph++) begin
      queue_policy(phase_policy[ph % 4]);
      sender_gap_pct = phase_gap[ph / 4];
      count = 0;
      while (count < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) begin
          n = $urandom_range(1, NBLK);
          repeat (n) queue_item(fpba_pkg::CMD_LOAD, $urandom_range(0, NBLK - 1),
                                random_amount());
          count += n;
          n = $urandom_range(1, 6);
          repeat (n) queue_item(fpba_pkg::CMD_ALLOC, $urandom_range(0, NBLK - 1),
                                random_amount());
          count += n;
        end else begin
          queue_item(1'($urandom_range(0, 1)), $urandom_range(0, NBLK - 1),
                     random_amount());
          count++;
        end
      end
    end

    while (pending_ops.size() != 0 || expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/fpba_pkg.sv
rtl/fpba_cap_mem.sv
rtl/fit_policy_block_allocator_unit.sv
rtl/fpba_checker.sv
test/tb_top.sv
